// ===== sv/rte_pkg.sv =====
package rte_pkg;

  localparam int GUARD        = 14;
  localparam int THR_W        = 15;
  localparam int IN_W         = 16;
  localparam int ANG_W        = 16;
  localparam int SQ_IN_W      = 2 * IN_W;
  localparam int SQRT_BITS    = 30;
  localparam int SQ_W         = 2 * SQRT_BITS + 1;
  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int ROUND_SH     = 17;
  // input reg, square reg, sqrt pipe, decision reg, cordic
  localparam int NV           = 3 + SQRT_BITS + 1 + CORDIC_LAT;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t QUARTER_TURN = 34'sd1686629713;
  localparam cw_t ROUND_ADD    = 34'sd65536;

  localparam cw_t ATAN_TAB [CORDIC_STEPS] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516,  34'sd16775851,  34'sd8388437,   34'sd4194283,   34'sd2097149,
    34'sd1048576,   34'sd524288,    34'sd262144,    34'sd131072,    34'sd65536,
    34'sd32768,     34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,       34'sd64,
    34'sd32,        34'sd16,        34'sd8,         34'sd4,         34'sd2
  };

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
  } mat_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_x;
    logic signed [ANG_W-1:0] angle_y;
    logic signed [ANG_W-1:0] angle_z;
    logic                    is_singular;
  } res_t;

  function automatic cw_t up(input logic signed [IN_W-1:0] v);
    up = CW'(v) <<< GUARD;
  endfunction

endpackage

// ===== sv/rte_if.sv =====
interface rte_in_if;
  import rte_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] r00;
  logic signed [IN_W-1:0] r10;
  logic signed [IN_W-1:0] r20;
  logic signed [IN_W-1:0] r21;
  logic signed [IN_W-1:0] r22;
  logic signed [IN_W-1:0] r11;
  logic signed [IN_W-1:0] r12;
  modport source(output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
  modport sink(input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

interface rte_out_if;
  import rte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_x;
  logic signed [ANG_W-1:0] angle_y;
  logic signed [ANG_W-1:0] angle_z;
  logic                    is_singular;
  modport source(output valid, angle_x, angle_y, angle_z, is_singular, input ready);
  modport sink(input valid, angle_x, angle_y, angle_z, is_singular, output ready);
endinterface

// ===== sv/rte_cordic.sv =====
module rte_cordic import rte_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  cw_t                     a_i,
  input  cw_t                     b_i,
  output logic signed [ANG_W-1:0] ang_o
);

  cw_t  x_r [0:CORDIC_STEPS];
  cw_t  y_r [0:CORDIC_STEPS];
  cw_t  z_r [0:CORDIC_STEPS];
  logic zf_r [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] ang_r;
  cw_t  px_nxt, py_nxt, pz_nxt;
  cw_t  zr;

  // quarter-turn into the right half plane
  always_comb begin
    px_nxt = b_i;
    py_nxt = a_i;
    pz_nxt = '0;
    if (b_i < 0) begin
      if (a_i >= 0) begin
        px_nxt = a_i;
        py_nxt = -b_i;
        pz_nxt = QUARTER_TURN;
      end else begin
        px_nxt = -a_i;
        py_nxt = b_i;
        pz_nxt = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= px_nxt;
      y_r[0]  <= py_nxt;
      z_r[0]  <= pz_nxt;
      zf_r[0] <= (a_i == '0) && (b_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign zr = z_r[CORDIC_STEPS] + ROUND_ADD;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zf_r[CORDIC_STEPS] ? '0 : ANG_W'(zr >>> ROUND_SH);
    end
  end

  assign ang_o = ang_r;

endmodule

// ===== sv/rotation_to_euler_angles.sv =====
// Rotation matrix to Z-Y-X Euler angles.
// in_ch carries seven Q1.14 matrix entries; out_ch returns angle_x,
// angle_y, angle_z (Q3.13 radians) and is_singular, one result per input.
// A transfer happens when valid and ready are both high.
// cfg_we/cfg_wdata write singular_threshold; write only while idle.
// Pipeline from input transfer to out_ch.valid: input reg, square reg,
// 31 square-root stages, branch select reg, 32 CORDIC stages, output reg.
// The square root and the three CORDIC units are
// one-bit/one-step-per-stage pipelines.
// Throughput: one matrix per cycle while in_ch.ready is high.
// Reset (rst_n low, synchronous) empties the pipeline and sets the
// threshold to 1.
// When out_ch.ready is low the result is held; one more result goes into
// a skid register, then in_ch.ready drops and the whole pipeline freezes.
// in_ch.ready depends only on registered state.
module rotation_to_euler_angles import rte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  rte_in_if.sink           in_ch,
  rte_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  logic             adv;
  logic [NV-1:0]    vld_r;
  logic [THR_W-1:0] thr_r;

  mat_t                 m0_r, m1_r;
  logic [SQ_IN_W-1:0]   sq00_r, sq10_r;
  logic signed [SQ_IN_W-1:0] p00, p10;

  logic [SQ_W-1:0]      rem_r  [0:SQRT_BITS];
  logic [SQRT_BITS-1:0] root_r [0:SQRT_BITS];
  mat_t                 sm_r   [0:SQRT_BITS];

  mat_t                 md;
  logic [SQRT_BITS-1:0] sy_f;
  logic                 sing_nxt;
  cw_t                  xa_r, xb_r, ya_r, yb_r, za_r, zb_r;
  logic                 sing_r [0:CORDIC_LAT];

  logic signed [ANG_W-1:0] ax, ay, az;
  res_t p_res;
  logic out_v_r, skid_v_r;
  res_t out_d_r, skid_d_r;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  assign p00 = m0_r.r00 * m0_r.r00;
  assign p10 = m0_r.r10 * m0_r.r10;

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r <= '{r00: in_ch.r00, r10: in_ch.r10, r20: in_ch.r20, r21: in_ch.r21,
                r22: in_ch.r22, r11: in_ch.r11, r12: in_ch.r12};
      m1_r    <= m0_r;
      sq00_r  <= p00;
      sq10_r  <= p10;
      rem_r[0]  <= {{(SQ_W-SQ_IN_W-2*GUARD){1'b0}}, sq00_r + sq10_r, {(2*GUARD){1'b0}}};
      root_r[0] <= '0;
      sm_r[0]   <= m1_r;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - k;
    logic [SQ_W-1:0] term;
    assign term = (SQ_W'(root_r[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        sm_r[k+1] <= sm_r[k];
        if (rem_r[k] >= term) begin
          rem_r[k+1]  <= rem_r[k] - term;
          root_r[k+1] <= root_r[k] | (SQRT_BITS'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  assign md       = sm_r[SQRT_BITS];
  assign sy_f     = root_r[SQRT_BITS];
  assign sing_nxt = (sy_f >> GUARD) < SQRT_BITS'(thr_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r <= sing_nxt ? -up(md.r12) : up(md.r21);
      xb_r <= sing_nxt ? up(md.r11) : up(md.r22);
      ya_r <= -up(md.r20);
      yb_r <= CW'(sy_f);
      za_r <= up(md.r10);
      zb_r <= up(md.r00);
      sing_r[0] <= sing_nxt;
      for (int j = 0; j < CORDIC_LAT; j++) begin
        sing_r[j+1] <= sing_r[j];
      end
    end
  end

  rte_cordic u_cx (.clk(clk), .en(adv), .a_i(xa_r), .b_i(xb_r), .ang_o(ax));
  rte_cordic u_cy (.clk(clk), .en(adv), .a_i(ya_r), .b_i(yb_r), .ang_o(ay));
  rte_cordic u_cz (.clk(clk), .en(adv), .a_i(za_r), .b_i(zb_r), .ang_o(az));

  always_comb begin
    p_res.angle_x     = ax;
    p_res.angle_y     = ay;
    p_res.angle_z     = sing_r[CORDIC_LAT] ? '0 : az;
    p_res.is_singular = sing_r[CORDIC_LAT];
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[NV-1]) begin
      if (out_v_r && !out_ch.ready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ch.ready) begin
        out_d_r <= skid_d_r;
      end
    end else if (vld_r[NV-1]) begin
      if (out_v_r && !out_ch.ready) begin
        skid_d_r <= p_res;
      end else begin
        out_d_r <= p_res;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.angle_x     = out_d_r.angle_x;
  assign out_ch.angle_y     = out_d_r.angle_y;
  assign out_ch.angle_z     = out_d_r.angle_z;
  assign out_ch.is_singular = out_d_r.is_singular;

endmodule

// ===== sv/rte_checker.sv =====
module rte_checker import rte_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ANG_W-1:0] angle_x,
  input logic signed [ANG_W-1:0] angle_z,
  input logic                    is_singular
);

  localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sd25736;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_sing_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_singular |-> angle_z == '0)
    else $error("angle_z nonzero on singular result");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_x <= ANG_MAX) && (angle_x >= -ANG_MAX))
    else $error("angle_x out of range");

endmodule

bind rotation_to_euler_angles rte_checker u_rte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .angle_x    (out_ch.angle_x),
  .angle_z    (out_ch.angle_z),
  .is_singular(out_ch.is_singular)
);
